### sv/vpr_pkg.sv
// constants, request codes and register indexes for the varispeed ring playback block
// no dependencies
package vpr_pkg;

    localparam int RING_FRAMES = 32768;
    localparam int FRAC_BITS   = 16;

    localparam int RING_AW    = $clog2(RING_FRAMES);
    localparam int BANK_DEPTH = RING_FRAMES / 2;
    localparam int BANK_AW    = RING_AW - 1;
    localparam int POS_W      = RING_AW + FRAC_BITS;
    localparam int FPOS_W     = 32 + FRAC_BITS + 1;
    localparam int SAMPLE_W   = 16;
    localparam int RATE_W     = 21;
    localparam int FRAME_W    = 2 * SAMPLE_W;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LEN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_MGN = CFG_IDX_W'(1);

    localparam logic [15:0] REFILL_MGN_RST = 16'd16384;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_TICK = 2'd1,
        REQ_SEEK = 2'd2
    } t_req;

endpackage

### sv/vpr_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module vpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/vpr_lerp.sv
// linear interpolation of one channel: a + floor((b - a) * frac / 2^FRAC_BITS)
// depends on vpr_pkg
module vpr_lerp (
    input  logic signed [vpr_pkg::SAMPLE_W-1:0]  i_a,
    input  logic signed [vpr_pkg::SAMPLE_W-1:0]  i_b,
    input  logic        [vpr_pkg::FRAC_BITS-1:0] i_frac,
    output logic signed [vpr_pkg::SAMPLE_W-1:0]  o_y
);
    import vpr_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic signed [DIFF_W-1:0]      diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      prod_sh;

    always_comb begin
        diff    = DIFF_W'(i_b) - DIFF_W'(i_a);
        frac_s  = $signed({1'b0, i_frac});
        prod    = PROD_W'(diff) * PROD_W'(frac_s);
        // arithmetic shift gives the floor
        prod_sh = prod >>> FRAC_BITS;
        o_y     = i_a + prod_sh[SAMPLE_W-1:0];
    end

endmodule

### sv/varispeed_ring_playback.sv
// varispeed_ring_playback: stereo variable-rate playback from a frame ring
// depends on vpr_pkg, vpr_ram (even and odd frame banks) and vpr_lerp
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    req_type, load_left/right, play_rate,
//                                                   seek_frame
//   out       output     o_out_valid / i_out_ready  out_left, out_right, need_refill, at_end
//   cfg       input      i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// one item is accepted per cycle when the output is taken; its result passes through the ring
// read stage, then the output register
// the ring is split into even and odd frame banks so both interpolation frames are read
// in the same cycle
// after reset both banks are cleared, one row per cycle, RING_FRAMES/2 = 16384 rows in all,
// with o_in_ready low; configuration writes are taken throughout
// a stalled output holds one more item in the read stage before o_in_ready drops
module varispeed_ring_playback (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_req_type,
    input  logic signed [vpr_pkg::SAMPLE_W-1:0]  i_load_left,
    input  logic signed [vpr_pkg::SAMPLE_W-1:0]  i_load_right,
    input  logic signed [vpr_pkg::RATE_W-1:0]    i_play_rate,
    input  logic [31:0]                          i_seek_frame,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [vpr_pkg::SAMPLE_W-1:0]  o_out_left,
    output logic signed [vpr_pkg::SAMPLE_W-1:0]  o_out_right,
    output logic                                 o_need_refill,
    output logic                                 o_at_end,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vpr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [vpr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import vpr_pkg::*;

    localparam int FSUM_W  = FPOS_W + 1;
    localparam int AHEAD_W = 34;

    localparam logic signed [FPOS_W-1:0] FPOS_MAX = {1'b0, {(FPOS_W-1){1'b1}}};
    localparam logic signed [FPOS_W-1:0] FPOS_MIN = {1'b1, {(FPOS_W-1){1'b0}}};

    // configuration
    logic [31:0]              r_track_len;
    logic [15:0]              r_refill_mgn;

    // playback state
    logic [POS_W-1:0]         r_rpos,   n_rpos;
    logic signed [FPOS_W-1:0] r_fpos,   n_fpos;
    logic [31:0]              r_loaded, n_loaded;
    logic [RING_AW-1:0]       r_wr_idx, n_wr_idx;

    // clearing pass
    logic                     r_clr_busy;
    logic [BANK_AW-1:0]       r_clr_addr;

    // read stage
    logic                     r_b_vld;
    logic                     r_b_tick, n_b_tick;
    logic                     r_b_sel;
    logic [FRAC_BITS-1:0]     r_b_frac;

    // output register
    logic                          r_o_vld;
    logic signed [SAMPLE_W-1:0]    r_o_left;
    logic signed [SAMPLE_W-1:0]    r_o_right;
    logic                          r_o_refill;
    logic                          r_o_end;

    logic                     in_acc;
    logic                     b_move;
    logic                     past_end;
    logic                     silent;
    logic signed [FPOS_W-1:0] track_fp;
    logic signed [FSUM_W-1:0] fsum;
    logic [31:0]              seek_t;
    logic [RING_AW-1:0]       prev_frame;

    logic                     even_we, odd_we;
    logic [BANK_AW-1:0]       bank_waddr;
    logic [FRAME_W-1:0]       bank_wdata;
    logic [BANK_AW-1:0]       even_raddr, odd_raddr;
    logic [FRAME_W-1:0]       even_q, odd_q;

    logic [FRAME_W-1:0]         frame_a, frame_b;
    logic signed [SAMPLE_W-1:0] lerp_left, lerp_right;
    logic signed [SAMPLE_W-1:0] res_left, res_right;
    logic signed [FPOS_W-FRAC_BITS-1:0] fpos_int;
    logic signed [AHEAD_W-1:0]  ahead;
    logic                       refill;

    assign b_move      = r_b_vld && (!r_o_vld || i_out_ready);
    assign o_in_ready  = !r_clr_busy && (!r_b_vld || b_move);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign track_fp   = $signed({1'b0, r_track_len, {FRAC_BITS{1'b0}}});
    assign past_end   = r_fpos >= track_fp;
    assign silent     = (i_play_rate == '0) || past_end;
    assign seek_t     = (i_seek_frame > r_track_len) ? r_track_len : i_seek_frame;
    assign prev_frame = r_rpos[POS_W-1:FRAC_BITS];
    assign fsum       = FSUM_W'(r_fpos) + FSUM_W'(i_play_rate);

    // state update at accept
    always_comb begin
        n_rpos   = r_rpos;
        n_fpos   = r_fpos;
        n_loaded = r_loaded;
        n_wr_idx = r_wr_idx;
        n_b_tick = 1'b0;
        if (in_acc) begin
            unique case (i_req_type)
                REQ_LOAD: begin
                    n_wr_idx = r_wr_idx + RING_AW'(1);
                    if (r_loaded != '1) begin
                        n_loaded = r_loaded + 32'd1;
                    end
                end
                REQ_TICK: begin
                    if (!silent) begin
                        n_b_tick = 1'b1;
                        // ring position wraps modulo the ring span
                        n_rpos   = r_rpos + POS_W'(i_play_rate);
                        if (fsum[FSUM_W-1] != fsum[FSUM_W-2]) begin
                            n_fpos = fsum[FSUM_W-1] ? FPOS_MIN : FPOS_MAX;
                        end else begin
                            n_fpos = fsum[FPOS_W-1:0];
                        end
                    end
                end
                REQ_SEEK: begin
                    n_fpos   = $signed({1'b0, seek_t, {FRAC_BITS{1'b0}}});
                    n_loaded = seek_t;
                    n_rpos   = '0;
                    n_wr_idx = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // ring banks: even frames in one, odd frames in the other
    always_comb begin
        if (r_clr_busy) begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            bank_waddr = r_clr_addr;
            bank_wdata = '0;
        end else begin
            even_we    = in_acc && (i_req_type == REQ_LOAD) && !r_wr_idx[0];
            odd_we     = in_acc && (i_req_type == REQ_LOAD) && r_wr_idx[0];
            bank_waddr = r_wr_idx[RING_AW-1:1];
            bank_wdata = {i_load_left, i_load_right};
        end
        // the next frame lands in the even bank one row up when prev is odd
        even_raddr = prev_frame[RING_AW-1:1] + BANK_AW'(prev_frame[0]);
        odd_raddr  = prev_frame[RING_AW-1:1];
    end

    vpr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (even_we),
        .i_waddr (bank_waddr),
        .i_wdata (bank_wdata),
        .i_re    (in_acc),
        .i_raddr (even_raddr),
        .o_rdata (even_q)
    );

    vpr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (odd_we),
        .i_waddr (bank_waddr),
        .i_wdata (bank_wdata),
        .i_re    (in_acc),
        .i_raddr (odd_raddr),
        .o_rdata (odd_q)
    );

    // read stage: interpolate and build flags from the post-item state
    assign frame_a = r_b_sel ? odd_q : even_q;
    assign frame_b = r_b_sel ? even_q : odd_q;

    vpr_lerp u_lerp_left (
        .i_a    ($signed(frame_a[FRAME_W-1:SAMPLE_W])),
        .i_b    ($signed(frame_b[FRAME_W-1:SAMPLE_W])),
        .i_frac (r_b_frac),
        .o_y    (lerp_left)
    );

    vpr_lerp u_lerp_right (
        .i_a    ($signed(frame_a[SAMPLE_W-1:0])),
        .i_b    ($signed(frame_b[SAMPLE_W-1:0])),
        .i_frac (r_b_frac),
        .o_y    (lerp_right)
    );

    always_comb begin
        res_left  = r_b_tick ? lerp_left  : '0;
        res_right = r_b_tick ? lerp_right : '0;
        fpos_int  = r_fpos[FPOS_W-1:FRAC_BITS];
        ahead     = $signed({2'b00, r_loaded}) - AHEAD_W'(fpos_int);
        refill    = ahead < $signed({{(AHEAD_W-16){1'b0}}, r_refill_mgn});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_len  <= '0;
            r_refill_mgn <= REFILL_MGN_RST;
            r_rpos       <= '0;
            r_fpos       <= '0;
            r_loaded     <= '0;
            r_wr_idx     <= '0;
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_b_vld      <= 1'b0;
            r_b_tick     <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_TRACK_LEN) begin
                    r_track_len <= i_cfg_data[31:0];
                end else if (i_cfg_index == CFG_REFILL_MGN) begin
                    r_refill_mgn <= i_cfg_data[15:0];
                end
            end
            r_rpos   <= n_rpos;
            r_fpos   <= n_fpos;
            r_loaded <= n_loaded;
            r_wr_idx <= n_wr_idx;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + BANK_AW'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc) begin
                r_b_vld  <= 1'b1;
                r_b_tick <= n_b_tick;
            end else if (b_move) begin
                r_b_vld  <= 1'b0;
            end
            if (b_move) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_sel  <= prev_frame[0];
            r_b_frac <= r_rpos[FRAC_BITS-1:0];
        end
        if (b_move) begin
            r_o_left   <= res_left;
            r_o_right  <= res_right;
            r_o_refill <= refill;
            r_o_end    <= past_end;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_out_left    = r_o_left;
    assign o_out_right   = r_o_right;
    assign o_need_refill = r_o_refill;
    assign o_at_end      = r_o_end;

    // no item enters while the banks are being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("item accepted during ring clearing pass");

    // the read stage is never overwritten while it holds an item
    a_read_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && !b_move) |-> !in_acc)
        else $error("read stage overwritten while stalled");

    // a seek rewinds the ring
    a_seek_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_SEEK) |=> (r_wr_idx == '0 && r_rpos == '0))
        else $error("seek did not rewind ring positions");

    // a silent tick leaves the ring position alone
    a_silent_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_TICK && silent) |=> $stable(r_rpos))
        else $error("silent tick moved the ring position");

endmodule

### tb/varispeed_ring_playback_test.sv
// self-checking testbench for varispeed_ring_playback: loads, seeks and rate ticks
// checked against a cycle-free mirror of the ring and play positions; needs vpr_pkg
`timescale 1ns / 1ps

module varispeed_ring_playback_test;
    import vpr_pkg::*;

    localparam logic [1:0]           REQ_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;
    localparam int                   QUIET_LIMIT   = 80000;
    localparam int                   SETTLE_CYCLES = 8;
    localparam int                   REPORT_CAP    = 100;
    localparam longint               FILE_POS_MAX  = (longint'(1) <<< (FPOS_W - 1)) - 1;
    localparam longint               FILE_POS_MIN  = -FILE_POS_MAX - 1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] smp_l;
        logic [SAMPLE_W-1:0] smp_r;
        logic [RATE_W-1:0]   rate;
        logic [31:0]         seek;
    } play_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp_l;
        logic [SAMPLE_W-1:0] smp_r;
        logic                need_refill;
        logic                at_end;
    } play_frame_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [1:0]                 i_req_type;
    logic signed [SAMPLE_W-1:0] i_load_left;
    logic signed [SAMPLE_W-1:0] i_load_right;
    logic signed [RATE_W-1:0]   i_play_rate;
    logic [31:0]                i_seek_frame;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [SAMPLE_W-1:0] o_out_left;
    logic signed [SAMPLE_W-1:0] o_out_right;
    logic                       o_need_refill;
    logic                       o_at_end;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    // mirror of the block state
    logic signed [SAMPLE_W-1:0] mir_ring_l [RING_FRAMES];
    logic signed [SAMPLE_W-1:0] mir_ring_r [RING_FRAMES];
    logic [POS_W-1:0]           mir_ring_pos;
    logic signed [FPOS_W-1:0]   mir_file_pos;
    logic [31:0]                mir_loaded;
    logic [RING_AW-1:0]         mir_wr_idx;
    logic [31:0]                mir_track_len;
    logic [15:0]                mir_margin;

    play_frame_t frames_due [$];

    int n_errors      = 0;
    int quiet_cycles  = 0;
    int snd_idle_pct  = 13;
    int rcv_idle_pct  = 72;
    int rcv_hold_req  = 0;
    int rcv_hold_left = 0;

    varispeed_ring_playback u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_load_left   (i_load_left),
        .i_load_right  (i_load_right),
        .i_play_rate   (i_play_rate),
        .i_seek_frame  (i_seek_frame),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_left    (o_out_left),
        .o_out_right   (o_out_right),
        .o_need_refill (o_need_refill),
        .o_at_end      (o_at_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic void reset_mirror();
        for (int k = 0; k < RING_FRAMES; k++) begin
            mir_ring_l[k] = '0;
            mir_ring_r[k] = '0;
        end
        mir_ring_pos  = '0;
        mir_file_pos  = '0;
        mir_loaded    = '0;
        mir_wr_idx    = '0;
        mir_track_len = '0;
        mir_margin    = REFILL_MGN_RST;
    endfunction

    function automatic logic playback_done();
        longint fp;
        longint lim;
        fp  = mir_file_pos;
        lim = longint'({32'd0, mir_track_len}) << FRAC_BITS;
        return fp >= lim;
    endfunction

    // a + floor((b - a) * frac / 2^FRAC_BITS)
    function automatic logic [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] a,
                                                  input logic signed [SAMPLE_W-1:0] b,
                                                  input logic [FRAC_BITS-1:0] frac);
        longint p;
        longint sum;
        p   = (longint'(b) - longint'(a)) * longint'({1'b0, frac});
        sum = longint'(a) + (p >>> FRAC_BITS);
        return sum[SAMPLE_W-1:0];
    endfunction

    function automatic void predict_frame(input play_item_t it);
        play_frame_t        fr;
        longint             step;
        longint             fp;
        longint             ahead;
        logic [RING_AW-1:0] cur;
        logic [RING_AW-1:0] nxt;
        logic [31:0]        dest;
        fr = '0;
        case (it.kind)
            REQ_LOAD: begin
                mir_ring_l[mir_wr_idx] = it.smp_l;
                mir_ring_r[mir_wr_idx] = it.smp_r;
                mir_wr_idx = mir_wr_idx + 1'b1;
                if (mir_loaded != '1)
                    mir_loaded = mir_loaded + 1;
            end
            REQ_TICK: begin
                step = $signed(it.rate);
                if (step != 0 && !playback_done()) begin
                    cur = mir_ring_pos[POS_W-1:FRAC_BITS];
                    nxt = cur + 1'b1;
                    fr.smp_l = blend(mir_ring_l[cur], mir_ring_l[nxt],
                                     mir_ring_pos[FRAC_BITS-1:0]);
                    fr.smp_r = blend(mir_ring_r[cur], mir_ring_r[nxt],
                                     mir_ring_pos[FRAC_BITS-1:0]);
                    mir_ring_pos = mir_ring_pos + step[POS_W-1:0];
                    fp = mir_file_pos;
                    fp = fp + step;
                    if (fp > FILE_POS_MAX)
                        fp = FILE_POS_MAX;
                    else if (fp < FILE_POS_MIN)
                        fp = FILE_POS_MIN;
                    mir_file_pos = fp[FPOS_W-1:0];
                end
            end
            REQ_SEEK: begin
                dest = (it.seek > mir_track_len) ? mir_track_len : it.seek;
                mir_file_pos = {1'b0, dest, {FRAC_BITS{1'b0}}};
                mir_loaded   = dest;
                mir_ring_pos = '0;
                mir_wr_idx   = '0;
            end
            default: ;
        endcase
        fp    = mir_file_pos;
        ahead = longint'({32'd0, mir_loaded}) - (fp >>> FRAC_BITS);
        fr.need_refill = ahead < longint'({48'd0, mir_margin});
        fr.at_end      = playback_done();
        frames_due.push_back(fr);
    endfunction

    task automatic send_item(input play_item_t it);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_req_type   = it.kind;
        i_load_left  = it.smp_l;
        i_load_right = it.smp_r;
        i_play_rate  = it.rate;
        i_seek_frame = it.seek;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_frame(it);
    endtask

    // fields that the request ignores still get random values
    function automatic play_item_t noise_item();
        play_item_t it;
        it.kind  = 2'($urandom_range(3, 0));
        it.smp_l = 16'($urandom);
        it.smp_r = 16'($urandom);
        it.rate  = RATE_W'($urandom);
        it.seek  = $urandom;
        return it;
    endfunction

    task automatic send_load(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
        play_item_t it;
        it       = noise_item();
        it.kind  = REQ_LOAD;
        it.smp_l = l;
        it.smp_r = r;
        send_item(it);
    endtask

    task automatic send_tick(input logic [RATE_W-1:0] rate);
        play_item_t it;
        it      = noise_item();
        it.kind = REQ_TICK;
        it.rate = rate;
        send_item(it);
    endtask

    task automatic send_seek(input logic [31:0] frame);
        play_item_t it;
        it      = noise_item();
        it.kind = REQ_SEEK;
        it.seek = frame;
        send_item(it);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_TRACK_LEN)
            mir_track_len = data;
        else if (idx == CFG_REFILL_MGN)
            mir_margin = data[15:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop offering items and wait for every pending result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        if (n_errors < REPORT_CAP)
            $error("%s: expected %0d, got %0d", field, want, got);
        n_errors++;
    endtask

    // receiver side: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (rcv_hold_req != 0) begin
            rcv_hold_left = rcv_hold_req;
            rcv_hold_req  = 0;
        end
        if (rcv_hold_left > 0) begin
            rcv_hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_frames
        play_frame_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frames_due.size() == 0) begin
                if (n_errors < REPORT_CAP)
                    $error("result item with nothing expected");
                n_errors++;
            end else begin
                want = frames_due.pop_front();
                if (o_out_left !== want.smp_l)
                    flag_mismatch("out_left", $signed(want.smp_l), o_out_left);
                if (o_out_right !== want.smp_r)
                    flag_mismatch("out_right", $signed(want.smp_r), o_out_right);
                if (o_need_refill !== want.need_refill)
                    flag_mismatch("need_refill", want.need_refill, o_need_refill);
                if (o_at_end !== want.at_end)
                    flag_mismatch("at_end", want.at_end, o_at_end);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("varispeed_ring_playback_test: errors");
            $finish;
        end
    end

    task automatic test_directed_edges();
        cfg_write(CFG_TRACK_LEN, 32'd1000);
        cfg_write(CFG_REFILL_MGN, 32'd8);
        send_load(16'h8000, 16'h7fff);
        send_load(16'h7fff, 16'h8000);
        send_load(16'hffff, 16'h0001);
        send_load(16'h1234, 16'hedcc);
        send_tick(RATE_W'(0));              // zero rate stays silent
        send_tick(RATE_W'(1));
        send_tick(RATE_W'(32767));          // smallest fraction across full-scale step
        send_tick(RATE_W'(-32768));         // half way, then back to slot zero
        send_tick(RATE_W'(-1));             // ring position wraps below zero
        send_tick(RATE_W'(1));              // last slot blended with slot zero
        send_tick(RATE_W'(1048575));
        send_tick(RATE_W'(-1048576));       // file position goes negative
        send_tick(RATE_W'(-74565));
        send_item(noise_item() | {REQ_UNUSED, {($bits(play_item_t) - 2){1'b0}}});
        send_seek(32'd5000);                // clamped to the track length
        send_tick(RATE_W'(1));              // silent past the end
        send_seek(32'hffff_ffff);
        send_seek(32'd999);
        send_tick(RATE_W'(1048575));        // runs over the end
        send_seek(32'd0);
    endtask

    task automatic test_register_extremes();
        drain();
        cfg_write(CFG_TRACK_LEN, 32'hffff_ffff);
        cfg_write(CFG_REFILL_MGN, 32'h0000_ffff);
        send_seek(32'hffff_fffe);
        send_tick(RATE_W'(1048575));        // file position pins at its upper limit
        send_tick(RATE_W'(-65536));
        send_seek(32'hffff_ffff);
        send_load(16'h0f0f, 16'hf0f0);      // loaded count saturates
        send_load(16'h5555, 16'haaaa);
        drain();
        cfg_write(CFG_IDX_SPARE, 32'hdead_beef);  // no such register
        cfg_write(CFG_TRACK_LEN, 32'd0);
        cfg_write(CFG_REFILL_MGN, 32'd0);
        send_tick(RATE_W'(65536));
        send_seek(32'd77);
        send_tick(RATE_W'(-65536));
        send_load(16'h0001, 16'h8001);
    endtask

    task automatic test_random_playback(input int n_items, input int snd_pct, input int rcv_pct,
                                        input logic [31:0] track, input logic [15:0] margin);
        int sent;
        int roll;
        int n_loads;
        int n_ticks;
        int base;
        int pick;
        drain();
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        cfg_write(CFG_TRACK_LEN, track);
        cfg_write(CFG_REFILL_MGN, {16'd0, margin});
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_item(noise_item());
                sent++;
            end else begin
                if (roll < 40) begin
                    if ($urandom_range(9) == 0)
                        send_seek($urandom);
                    else
                        send_seek($urandom_range(mir_track_len, 0));
                    sent++;
                end
                // some bursts play with nothing freshly loaded
                n_loads = $urandom_range(40, 0);
                for (int k = 0; k < n_loads; k++)
                    send_load(16'($urandom), 16'($urandom));
                base    = int'($urandom_range(196608, 0)) - 65536;
                n_ticks = $urandom_range(40, 2);
                for (int k = 0; k < n_ticks; k++) begin
                    pick = $urandom_range(11);
                    if (pick == 0)
                        send_tick(RATE_W'(0));
                    else if (pick == 1)
                        send_tick(RATE_W'($urandom));
                    else
                        send_tick(RATE_W'(base + int'($urandom_range(512, 0)) - 256));
                end
                sent += n_loads + n_ticks;
            end
        end
    endtask

    task automatic test_output_backpressure();
        drain();
        rcv_hold_req = 400;
        send_seek(32'd0);
        for (int k = 0; k < 20; k++)
            send_load(16'($urandom), 16'($urandom));
        for (int k = 0; k < 20; k++)
            send_tick(RATE_W'($urandom_range(131072, 1)));
        // sender waits for the block to empty before going on
        drain();
        for (int k = 0; k < 10; k++)
            send_tick(RATE_W'($urandom_range(131072, 1)));
    endtask

    task automatic test_ring_wraparound();
        drain();
        cfg_write(CFG_TRACK_LEN, 32'hffff_ffff);
        send_seek(32'd0);
        for (int k = 0; k < 48; k++)
            send_load(16'($urandom), 16'($urandom));
        // step back below slot zero into the top of the ring, then forward across the end
        send_tick(RATE_W'(-1048576));
        send_tick(RATE_W'(-98304));
        for (int k = 0; k < 14; k++)
            send_tick(RATE_W'(98305));
        send_tick(RATE_W'(-1048576));
        send_tick(RATE_W'(-1048576));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_LOAD;
        i_load_left  = '0;
        i_load_right = '0;
        i_play_rate  = '0;
        i_seek_frame = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_TRACK_LEN;
        i_cfg_data   = '0;
        reset_mirror();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_register_extremes();
        test_random_playback(500, 13, 72, $urandom_range(20000, 2000),
                             16'($urandom_range(64, 0)));
        test_output_backpressure();
        test_random_playback(500, 72, 13, $urandom, 16'($urandom));
        test_random_playback(450, 0, 0, $urandom_range(100000, 500), REFILL_MGN_RST);
        test_ring_wraparound();
        drain();

        if (n_errors == 0) begin
            $display("varispeed_ring_playback_test: clean");
        end else begin
            $display("varispeed_ring_playback_test: errors");
        end
        $finish;
    end

endmodule

### sim.f
sv/vpr_pkg.sv
sv/vpr_ram.sv
sv/vpr_lerp.sv
sv/varispeed_ring_playback.sv
tb/varispeed_ring_playback_test.sv
